/* hdl/sha_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, operation codes, initial values and round constants.
// ----------------------------------------------------------------------------
package sha_pkg;
	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_ABSORB = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	typedef logic [7:0][31:0] chain_t;

	localparam chain_t IV_256 = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};
	localparam chain_t IV_224 = {
		32'hbefa4fa4, 32'h64f98fa7, 32'h68581511, 32'hffc00b31,
		32'hf70e5939, 32'h3070dd17, 32'h367cd507, 32'hc1059ed8};

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction
endpackage

/* hdl/sha_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface sha_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* hdl/sha256_hash_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 hash engine
// Byte-stream SHA-256 / SHA-224 hasher with valid/ready channels.
// ----------------------------------------------------------------------------
// Channels: in carries operation (start/absorb/finish) and data_byte; out
// carries one digest word per beat (word_index 0..7, last_word on index 7);
// cfg writes the one-bit variant register (0 SHA-256, 1 SHA-224 IV); the user
// must write it only while the engine is idle, which the block does not enforce.
// Front: a 4-deep command queue accepts beats whenever not full.
// Back: each absorb stores one byte; the 64th byte of a block starts a
// compression (load, one round per cycle, then add). Finish pads one byte
// per cycle, compresses once or twice, then streams 8 words.
// The core takes no command while it compresses, so absorbs wait in the queue.
// Reset loads the SHA-256 IV, clears counts and variant; out stalls simply
// hold the current word until taken, and the queue backs up into in.ready.
// ----------------------------------------------------------------------------
module sha256_hash_engine (
	input logic clk,
	input logic arst_n,
	sha_if.sink   in,
	sha_if.source out,
	sha_if.sink   cfg
);
	import sha_pkg::*;

	logic     variant_q;
	logic     q_full, q_empty, q_pop;
	in_item_t q_item;

	// configuration register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) variant_q <= 1'b0;
		else if (cfg.valid) variant_q <= cfg.payload;
	end

	assign in.ready = !q_full;

	sha_cmd_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(in.valid), .push_item(in.payload), .full(q_full),
		.pop(q_pop), .pop_item(q_item), .empty(q_empty)
	);

	sha_core u_core (
		.clk(clk), .arst_n(arst_n), .variant(variant_q),
		.cmd_valid(!q_empty), .cmd_item(q_item), .cmd_pop(q_pop),
		.out_valid(out.valid), .out_item(out.payload), .out_ready(out.ready)
	);
endmodule

/* hdl/sha_cmd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue
// Small FIFO decoupling the input front from the hashing back end.
// ----------------------------------------------------------------------------
module sha_cmd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sha_pkg::in_item_t push_item,
	output logic             full,
	input  logic             pop,
	output sha_pkg::in_item_t pop_item,
	output logic             empty
);
	import sha_pkg::*;
	in_item_t   mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;

	assign full     = cnt_q == 3'd4;
	assign empty    = cnt_q == 3'd0;
	assign pop_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wr_q <= wr_q + 2'd1;
			if (pop && !empty) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(push && !full) - 3'(pop && !empty);
		end
	end
endmodule

/* hdl/sha_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 back end
// Block buffer, padding sequencer, one-round-per-cycle compression, output.
// ----------------------------------------------------------------------------
module sha_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              variant,
	input  logic              cmd_valid,
	input  sha_pkg::in_item_t cmd_item,
	output logic              cmd_pop,
	output logic              out_valid,
	output sha_pkg::out_item_t out_item,
	input  logic              out_ready
);
	import sha_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_LOAD = 3'd2;
	localparam logic [2:0] ST_RND  = 3'd3;
	localparam logic [2:0] ST_ADD  = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;

	logic [2:0]  state_q;
	logic [31:0] blk_q [16];
	logic [5:0]  fill_q;
	logic [63:0] bitlen_q;
	chain_t      chain_q;
	chain_t      r_q;
	logic [31:0] w_q [16];
	logic [5:0]  rnd_q;
	logic        fin_q;
	logic        len_ok_q;
	logic [2:0]  oidx_q;
	logic        ovalid_q;

	logic [31:0] p, q, s0, s1, wnext, wcur, ch, maj, b0, b1, t1;

	function automatic logic [31:0] ror(input logic [31:0] v, input int s);
		return (v >> s) | (v << (32 - s));
	endfunction

	assign wcur = w_q[0];
	always_comb begin
		p     = w_q[14];
		q     = w_q[1];
		s1    = ror(p, 17) ^ ror(p, 19) ^ (p >> 10);
		s0    = ror(q, 7) ^ ror(q, 18) ^ (q >> 3);
		wnext = s1 + w_q[9] + s0 + w_q[0];
		ch    = (r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6]);
		maj   = (r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]);
		b1    = ror(r_q[4], 6) ^ ror(r_q[4], 11) ^ ror(r_q[4], 25);
		b0    = ror(r_q[0], 2) ^ ror(r_q[0], 13) ^ ror(r_q[0], 22);
		t1    = r_q[7] + b1 + ch + round_k(rnd_q) + wcur;
	end

	assign cmd_pop   = state_q == ST_IDLE && cmd_valid;
	assign out_valid = ovalid_q;
	always_comb begin
		out_item.digest_word = chain_q[oidx_q];
		out_item.word_index  = oidx_q;
		out_item.last_word   = oidx_q == 3'd7;
	end

	// byte write into the word buffer
	function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] pos,
		input logic [7:0] b);
		logic [31:0] r;
		r = w;
		r[8*(3-pos) +: 8] = b;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			bitlen_q <= '0;
			chain_q  <= IV_256;
			rnd_q    <= '0;
			fin_q    <= 1'b0;
			len_ok_q <= 1'b0;
			oidx_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						case (cmd_item.operation)
							OP_START: begin
								chain_q  <= variant ? IV_224 : IV_256;
								fill_q   <= '0;
								bitlen_q <= '0;
							end
							OP_ABSORB: begin
								blk_q[fill_q[5:2]] <= put_byte(blk_q[fill_q[5:2]], fill_q[1:0],
									cmd_item.data_byte);
								bitlen_q <= bitlen_q + 64'd8;
								fill_q   <= fill_q + 6'd1;
								fin_q    <= 1'b0;
								if (fill_q == 6'd63) state_q <= ST_LOAD;
							end
							OP_FINISH: begin
								blk_q[fill_q[5:2]] <= put_byte(blk_q[fill_q[5:2]], fill_q[1:0],
									8'h80);
								fill_q   <= fill_q + 6'd1;
								fin_q    <= 1'b1;
								len_ok_q <= fill_q <= 6'd55;
								state_q  <= (fill_q == 6'd63) ? ST_LOAD : ST_PAD;
							end
							default: ;
						endcase
					end
				end
				ST_PAD: begin
					// zero one byte per cycle; length fills bytes 56..63 once reached if it fits, else pad to 63
					if (len_ok_q && fill_q == 6'd56) begin
						blk_q[14] <= bitlen_q[63:32];
						blk_q[15] <= bitlen_q[31:0];
						fill_q    <= '0;
						state_q   <= ST_LOAD;
					end else begin
						blk_q[fill_q[5:2]] <= put_byte(blk_q[fill_q[5:2]], fill_q[1:0], 8'h00);
						fill_q <= fill_q + 6'd1;
						if (fill_q == 6'd63) state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					for (int i = 0; i < 16; i++) w_q[i] <= blk_q[i];
					r_q     <= chain_q;
					rnd_q   <= '0;
					state_q <= ST_RND;
				end
				ST_RND: begin
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= wnext;
					r_q[7] <= r_q[6]; r_q[6] <= r_q[5]; r_q[5] <= r_q[4];
					r_q[4] <= r_q[3] + t1;
					r_q[3] <= r_q[2]; r_q[2] <= r_q[1]; r_q[1] <= r_q[0];
					r_q[0] <= t1 + b0 + maj;
					rnd_q  <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + r_q[i];
					if (!fin_q) begin
						state_q <= ST_IDLE;
					end else if (!len_ok_q) begin
						len_ok_q <= 1'b1;
						fill_q   <= '0;
						state_q  <= ST_PAD;
					end else begin
						fin_q    <= 1'b0;
						fill_q   <= '0;
						bitlen_q <= '0;
						oidx_q   <= '0;
						ovalid_q <= 1'b1;
						state_q  <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							ovalid_q <= 1'b0;
							state_q  <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
